// ----- design/encr_pkg.sv -----
// Shared types and constants for the epsilon-closure removal core.
// Used by the controller, the datapath and the top level; depends on nothing.
package encr_pkg;

	// Fixed widths of the request and result fields
	localparam int IDX_W    = 3;
	localparam int OP_W     = 2;
	localparam int CNT_W    = 4;
	localparam int MASK_W   = 8;
	localparam int CFG_IDX_W = 1;

	// Largest state count the 3-bit state fields can address
	localparam int MAX_ROWS = 8;

	// Default sizes
	localparam int DEF_STATES  = 8;
	localparam int DEF_SYMBOLS = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SYMBOLS = 1'd1;

	// Request opcodes
	typedef enum logic [OP_W-1:0] {
		OP_EPS     = 2'd0,
		OP_LABEL   = 2'd1,
		OP_COMPUTE = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LD_WR,
		ST_CLOSE,
		ST_COL_RD,
		ST_COL_WAIT,
		ST_COL_WR,
		ST_EMIT
	} ctrl_state_t;

	// Datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_EPS_ADD,
		CMD_EDGE_RD,
		CMD_EDGE_WR,
		CMD_CLEAR,
		CMD_CLOS_INIT,
		CMD_CLOS_STEP,
		CMD_COL_RD,
		CMD_COL_WR,
		CMD_EMIT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] sym;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] ns_last;
		logic [IDX_W-1:0] nsym_last;
	} stat_t;

endpackage

// ----- design/encr_ctrl.sv -----
// Sequencer for the epsilon-closure removal core: loads, closure, merge, emit.
// Depends on encr_pkg; drives the datapath through cmd_t, reads stat_t.
module encr_ctrl
	import encr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [OP_W-1:0]  op,
	output logic             busy,
	input  stat_t            stat,
	output cmd_t             cmd
);

	ctrl_state_t state_q, state_d;
	logic [IDX_W-1:0] row_q, sym_q;
	logic row_end, sym_end;
	op_t req_op;

	assign req_op  = op_t'(op);
	assign row_end = (row_q == stat.ns_last);
	assign sym_end = (sym_q == stat.nsym_last);
	assign busy    = (state_q != ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req_op)
						OP_LABEL:   state_d = ST_LD_WR;
						OP_COMPUTE: state_d = ST_CLOSE;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_LD_WR:    state_d = ST_IDLE;
			ST_CLOSE:    if (row_end) state_d = ST_COL_RD;
			ST_COL_RD:   if (row_end) state_d = ST_COL_WAIT;
			ST_COL_WAIT: state_d = ST_COL_WR;
			ST_COL_WR: begin
				if (row_end) state_d = sym_end ? ST_EMIT : ST_COL_RD;
			end
			ST_EMIT:     if (row_end && sym_end) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd.op   = CMD_NONE;
		cmd.row  = row_q;
		cmd.sym  = sym_q;
		cmd.last = row_end && sym_end;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req_op)
						OP_EPS:     cmd.op = CMD_EPS_ADD;
						OP_LABEL:   cmd.op = CMD_EDGE_RD;
						OP_COMPUTE: cmd.op = CMD_CLOS_INIT;
						OP_CLEAR:   cmd.op = CMD_CLEAR;
						default:    cmd.op = CMD_NONE;
					endcase
				end
			end
			ST_LD_WR:    cmd.op = CMD_EDGE_WR;
			ST_CLOSE:    cmd.op = CMD_CLOS_STEP;
			ST_COL_RD:   cmd.op = CMD_COL_RD;
			ST_COL_WAIT: cmd.op = CMD_NONE;
			ST_COL_WR:   cmd.op = CMD_COL_WR;
			ST_EMIT:     cmd.op = CMD_EMIT;
			default:     cmd.op = CMD_NONE;
		endcase
	end

	// State and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			sym_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLOSE, ST_COL_RD: begin
					row_q <= row_end ? '0 : row_q + 1'b1;
				end
				// symbol column is kept across the read wait
				ST_COL_WAIT: ;
				ST_COL_WR: begin
					if (row_end) begin
						row_q <= '0;
						sym_q <= sym_end ? '0 : sym_q + 1'b1;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (sym_end) begin
						sym_q <= '0;
						row_q <= row_end ? '0 : row_q + 1'b1;
					end else begin
						sym_q <= sym_q + 1'b1;
					end
				end
				default: begin
					row_q <= '0;
					sym_q <= '0;
				end
			endcase
		end
	end

endmodule

// ----- design/encr_datapath.sv -----
// Datapath: count registers, epsilon and closure matrices, edge-row memory,
// column buffer and result registers. Depends on encr_pkg; driven by encr_ctrl.
module encr_datapath
	import encr_pkg::*;
#(
	parameter int STATES  = DEF_STATES,
	parameter int SYMBOLS = DEF_SYMBOLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	input  logic [IDX_W-1:0]     from_state,
	input  logic [IDX_W-1:0]     symbol_index,
	input  logic [IDX_W-1:0]     to_state,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output logic                 strobe,
	output logic [IDX_W-1:0]     row_state,
	output logic [IDX_W-1:0]     row_symbol,
	output logic [MASK_W-1:0]    target_mask,
	output logic                 last
);

	localparam int NROW  = (STATES < MAX_ROWS) ? STATES : MAX_ROWS;
	localparam int RW    = NROW;
	localparam int SW    = $clog2(NROW);
	localparam int DEPTH = NROW * SYMBOLS;
	localparam int AW    = $clog2(DEPTH);

	logic [CNT_W-1:0] num_states_q, num_symbols_q;
	logic [CNT_W-1:0] ns, nsym;
	logic [RW-1:0]    keep;

	logic [RW-1:0] eps_q  [NROW];
	logic [RW-1:0] clos_q [NROW];
	logic [RW-1:0] col_q  [NROW];
	logic [DEPTH-1:0] valid_q, in_range;

	logic [RW-1:0] mem [DEPTH];
	logic [RW-1:0] rdata_q;
	logic          rvalid_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic [RW-1:0] mem_wdata;
	logic [RW-1:0] merged;

	logic [IDX_W-1:0] from_q, sym_q, to_q;
	logic             eps_ok, edge_ok;

	logic          col_ld_s1;
	logic [SW-1:0] col_idx_s1;
	logic             strobe_s1, last_s1;
	logic [IDX_W-1:0] row_s1, sym_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q  <= CNT_W'(DEF_STATES);
			num_symbols_q <= CNT_W'(DEF_SYMBOLS);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_NUM_STATES:  num_states_q  <= cfg_data;
				REG_NUM_SYMBOLS: num_symbols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective counts, clamped into range
	always_comb begin
		if (num_states_q == '0)                ns = CNT_W'(1);
		else if (num_states_q > CNT_W'(NROW))  ns = CNT_W'(NROW);
		else                                   ns = num_states_q;
		if (num_symbols_q == '0)                 nsym = CNT_W'(1);
		else if (num_symbols_q > CNT_W'(SYMBOLS)) nsym = CNT_W'(SYMBOLS);
		else                                     nsym = num_symbols_q;
	end

	assign stat.ns_last   = IDX_W'(ns - CNT_W'(1));
	assign stat.nsym_last = IDX_W'(nsym - CNT_W'(1));

	always_comb begin
		for (int j = 0; j < RW; j++) keep[j] = (CNT_W'(j) < ns);
	end

	// Entries inside the active states-by-symbols window
	for (genvar a = 0; a < DEPTH; a++) begin : g_range
		assign in_range[a] = (CNT_W'(a / SYMBOLS) < ns) && (CNT_W'(a % SYMBOLS) < nsym);
	end

	// Load range checks
	assign eps_ok  = (CNT_W'(from_state) < ns) && (CNT_W'(to_state) < ns);
	assign edge_ok = (CNT_W'(from_q) < ns) && (CNT_W'(to_q) < ns) && (CNT_W'(sym_q) < nsym);

	// Union of buffered column rows over the closure of the current row
	always_comb begin
		merged = '0;
		for (int c = 0; c < NROW; c++) begin
			if (clos_q[cmd.row[SW-1:0]][c]) merged = merged | col_q[c];
		end
	end

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = AW'(int'(cmd.row) * SYMBOLS + int'(cmd.sym));
		mem_wdata = merged & keep;
		unique case (cmd.op)
			CMD_EDGE_RD: begin
				mem_re   = 1'b1;
				mem_addr = AW'(int'(from_state) * SYMBOLS + int'(symbol_index));
			end
			CMD_EDGE_WR: begin
				mem_we    = edge_ok;
				mem_addr  = AW'(int'(from_q) * SYMBOLS + int'(sym_q));
				mem_wdata = (rvalid_q ? rdata_q : {RW{1'b0}}) | (RW'(1) << to_q[SW-1:0]);
			end
			CMD_COL_RD, CMD_EMIT: mem_re = 1'b1;
			CMD_COL_WR:           mem_we = 1'b1;
			default: ;
		endcase
	end

	// Edge-row memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) begin
			rdata_q  <= mem[mem_addr];
			rvalid_q <= valid_q[mem_addr];
		end
	end

	// Per-entry valid bits; an invalid entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			unique case (cmd.op)
				CMD_CLEAR:     valid_q <= '0;
				CMD_CLOS_INIT: valid_q <= valid_q & in_range;
				default:       if (mem_we) valid_q[mem_addr] <= 1'b1;
			endcase
		end
	end

	// Epsilon and closure matrices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NROW; i++) begin
				eps_q[i]  <= '0;
				clos_q[i] <= '0;
			end
		end else begin
			unique case (cmd.op)
				CMD_CLEAR: begin
					for (int i = 0; i < NROW; i++) begin
						eps_q[i]  <= '0;
						clos_q[i] <= '0;
					end
				end
				CMD_EPS_ADD: begin
					if (eps_ok) begin
						eps_q[from_state[SW-1:0]] <= eps_q[from_state[SW-1:0]] |
							(RW'(1) << to_state[SW-1:0]);
					end
				end
				CMD_CLOS_INIT: begin
					for (int i = 0; i < NROW; i++) begin
						clos_q[i] <= keep[i] ? ((eps_q[i] | (RW'(1) << i)) & keep) : '0;
					end
				end
				CMD_CLOS_STEP: begin
					// one Warshall pivot: row k is unchanged during its own step
					for (int i = 0; i < NROW; i++) begin
						if (clos_q[i][cmd.row[SW-1:0]])
							clos_q[i] <= clos_q[i] | clos_q[cmd.row[SW-1:0]];
					end
				end
				default: ;
			endcase
		end
	end

	// Latched labeled-edge request for the read-modify-write
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_EDGE_RD) begin
			from_q <= from_state;
			sym_q  <= symbol_index;
			to_q   <= to_state;
		end
	end

	// Column buffer fill, in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_ld_s1 <= 1'b0;
		end else begin
			col_ld_s1 <= (cmd.op == CMD_COL_RD);
		end
	end

	always_ff @(posedge clk) begin
		col_idx_s1 <= cmd.row[SW-1:0];
		if (col_ld_s1) col_q[col_idx_s1] <= rvalid_q ? rdata_q : '0;
	end

	// Result stage, aligned with the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= (cmd.op == CMD_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_EMIT) begin
			row_s1  <= cmd.row;
			sym_s1  <= cmd.sym;
			last_s1 <= cmd.last;
		end
	end

	assign strobe      = strobe_s1;
	assign row_state   = row_s1;
	assign row_symbol  = sym_s1;
	assign last        = last_s1;
	assign target_mask = MASK_W'(rvalid_q ? rdata_q : {RW{1'b0}});

endmodule

// ----- design/epsilon_nfa_closure_removal_core.sv -----
// Epsilon-closure removal core: loads an automaton by request, then emits
// epsilon-free transition rows. A request is taken when start is high and busy
// is low; epsilon-edge and clear requests leave busy low. A labeled-edge
// request is a read-modify-write of the edge-row memory. A compute request
// keeps busy high through a Warshall pivot per state, then per symbol a column
// read, a wait and a column write-back through the single memory port, then one
// memory read per result; its last result leaves in the cycle after the last
// busy cycle. Results leave one a cycle, state major and symbol minor, each
// valid for exactly one cycle with strobe high; they cannot be held off, so the
// receiver must take them as they come. Depends on encr_pkg.
module epsilon_nfa_closure_removal_core
	import encr_pkg::*;
#(
	parameter int STATES  = DEF_STATES,
	parameter int SYMBOLS = DEF_SYMBOLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic [OP_W-1:0]      op,
	input  logic [IDX_W-1:0]     from_state,
	input  logic [IDX_W-1:0]     symbol_index,
	input  logic [IDX_W-1:0]     to_state,
	output logic                 strobe,
	output logic [IDX_W-1:0]     row_state,
	output logic [IDX_W-1:0]     row_symbol,
	output logic [MASK_W-1:0]    target_mask,
	output logic                 last
);

	cmd_t  cmd;
	stat_t stat;

	encr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	encr_datapath #(
		.STATES  (STATES),
		.SYMBOLS (SYMBOLS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.from_state   (from_state),
		.symbol_index (symbol_index),
		.to_state     (to_state),
		.cmd          (cmd),
		.stat         (stat),
		.strobe       (strobe),
		.row_state    (row_state),
		.row_symbol   (row_symbol),
		.target_mask  (target_mask),
		.last         (last)
	);

endmodule
